>>> hdl/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types, sizes and codes for the multi-voice sample mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

  // block configuration
  localparam int NUM_VOICES      = 4;
  localparam int OUT_RATE        = 11025;
  localparam int STORE_ADDR_BITS = 16;
  localparam int STORE_DEPTH     = 2 ** STORE_ADDR_BITS;

  // derived sizes
  localparam int VIDX_W  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int STEP_W  = $clog2(((65535 * 256) / OUT_RATE) + 1);
  localparam int POS_W   = 25;                                  // 16.8 plus carry
  localparam int ACC_W   = 9 + $clog2(NUM_VOICES);
  localparam int MASK_W  = 4;

  // step = rate * 256 / OUT_RATE as (rate * RECIP_MUL) >> RECIP_SHIFT;
  // the rounding error of RECIP_MUL stays below OUT_RATE, so the product is
  // exact for every 16-bit rate
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 32;
  localparam int PROD_W      = 16 + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'(((64'd1 << (RECIP_SHIFT + 8)) + 64'(OUT_RATE - 1)) / 64'(OUT_RATE));

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // start status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_VOICE  = 2'd1;
  localparam logic [1:0] ST_BAD_FORMAT = 2'd2;

  localparam logic [15:0] FORMAT_OK = 16'd3;

  localparam int MIX_MAX = 127;
  localparam int MIX_MIN = -128;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [2:0]  voice;
    logic [15:0] format_code;
    logic [15:0] sample_rate;
    logic [15:0] sample_count;
  } in_t;

  typedef struct packed {
    logic signed [7:0] mix_sample;
    logic              sample_valid;
    logic [1:0]        status;
    logic [3:0]        active_mask;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic store_write;
    logic step_load;
    logic voice_write;
    logic mix_clear;
    logic mix_accum;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       start_bad;
    logic       last_voice;
  } sts_t;

endpackage

>>> hdl/mvsm_ram.sv
// ----------------------------------------------------------------------------
// mvsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/mvsm_datapath.sv
// ----------------------------------------------------------------------------
// mvsm_datapath
// Item register, sample store, step multiplier, voice state, mix accumulator
// and result register.
// ----------------------------------------------------------------------------
module mvsm_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  mvsm_pkg::in_t  in_data,
  input  mvsm_pkg::cmd_t cmd,
  output mvsm_pkg::sts_t sts,
  output mvsm_pkg::out_t out_data
);

  localparam int AW = mvsm_pkg::STORE_ADDR_BITS;
  localparam logic signed [mvsm_pkg::ACC_W-1:0] SAT_HI =
    mvsm_pkg::ACC_W'(mvsm_pkg::MIX_MAX);
  localparam logic signed [mvsm_pkg::ACC_W-1:0] SAT_LO =
    mvsm_pkg::ACC_W'(mvsm_pkg::MIX_MIN);

  mvsm_pkg::in_t  item_r;
  mvsm_pkg::out_t out_data_r;

  // step
  logic [mvsm_pkg::PROD_W-1:0] step_prod;
  logic [mvsm_pkg::STEP_W-1:0] q_r;

  // voice state
  logic [15:0]                  base_r [mvsm_pkg::NUM_VOICES];
  logic [mvsm_pkg::STEP_W-1:0]  step_r [mvsm_pkg::NUM_VOICES];
  logic [mvsm_pkg::POS_W-1:0]   pos_r  [mvsm_pkg::NUM_VOICES];
  logic [15:0]                  cnt_r  [mvsm_pkg::NUM_VOICES];
  logic [mvsm_pkg::NUM_VOICES-1:0] active_r;

  // mix
  logic [mvsm_pkg::VIDX_W-1:0]       vidx_r;
  logic signed [mvsm_pkg::ACC_W-1:0] acc_r;

  logic                           bad_voice;
  logic                           bad_format;
  logic [AW-1:0]                  rd_addr;
  logic [7:0]                     rd_data;
  logic signed [7:0]              centered;
  logic [mvsm_pkg::POS_W-1:0]     pos_nxt;
  logic [mvsm_pkg::POS_W-1:0]     len_cur;
  logic [mvsm_pkg::VIDX_W-1:0]    wr_vidx;
  logic signed [7:0]              sat;
  logic [1:0]                     status_cur;
  logic [7:0]                     act_pad;

  // start checks
  always_comb begin
    bad_voice  = {29'd0, item_r.voice} >= 32'(mvsm_pkg::NUM_VOICES);
    bad_format = item_r.format_code != mvsm_pkg::FORMAT_OK;
    if (bad_voice) begin
      status_cur = mvsm_pkg::ST_BAD_VOICE;
    end else if (bad_format) begin
      status_cur = mvsm_pkg::ST_BAD_FORMAT;
    end else begin
      status_cur = mvsm_pkg::ST_OK;
    end
  end

  assign sts.kind       = item_r.kind;
  assign sts.start_bad  = bad_voice || bad_format;
  assign sts.last_voice = vidx_r == mvsm_pkg::VIDX_W'(mvsm_pkg::NUM_VOICES - 1);

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // sample store
  assign rd_addr = AW'(base_r[vidx_r]) + AW'(pos_r[vidx_r][mvsm_pkg::POS_W-1:8]);

  mvsm_ram #(
    .WIDTH(8),
    .DEPTH(mvsm_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store_write),
    .waddr(AW'(item_r.address)),
    .wdata(item_r.data_byte),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // step = rate * 256 / OUT_RATE by reciprocal multiply, 16 by 27 bits in effect
  assign step_prod = mvsm_pkg::PROD_W'(item_r.sample_rate) *
                     mvsm_pkg::PROD_W'(mvsm_pkg::RECIP_MUL);

  always_ff @(posedge clk) begin
    if (cmd.step_load) begin
      q_r <= step_prod[mvsm_pkg::RECIP_SHIFT +: mvsm_pkg::STEP_W];
    end
  end

  // byte taken as unsigned minus 128, position advance and end test
  assign centered = signed'({~rd_data[7], rd_data[6:0]});
  assign pos_nxt  = pos_r[vidx_r] + mvsm_pkg::POS_W'(step_r[vidx_r]);
  assign len_cur  = mvsm_pkg::POS_W'({cnt_r[vidx_r], 8'h00});
  assign wr_vidx  = item_r.voice[mvsm_pkg::VIDX_W-1:0];

  // voice state and mix accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      if (cmd.voice_write) begin
        active_r[wr_vidx] <= item_r.sample_count != 16'd0;
      end else if (cmd.mix_accum && active_r[vidx_r] && pos_nxt >= len_cur) begin
        active_r[vidx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.voice_write) begin
      base_r[wr_vidx] <= item_r.address;
      step_r[wr_vidx] <= q_r;
      pos_r[wr_vidx]  <= '0;
      cnt_r[wr_vidx]  <= item_r.sample_count;
    end else if (cmd.mix_accum && active_r[vidx_r]) begin
      pos_r[vidx_r] <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix_clear) begin
      acc_r  <= '0;
      vidx_r <= '0;
    end else if (cmd.mix_accum) begin
      if (active_r[vidx_r]) begin
        acc_r <= acc_r + mvsm_pkg::ACC_W'(centered);
      end
      if (sts.last_voice) begin
        vidx_r <= '0;
      end else begin
        vidx_r <= vidx_r + 1'b1;
      end
    end
  end

  // saturation and result register
  always_comb begin
    if (acc_r > SAT_HI) begin
      sat = 8'sd127;
    end else if (acc_r < SAT_LO) begin
      sat = -8'sd128;
    end else begin
      sat = acc_r[7:0];
    end
  end

  assign act_pad = 8'(active_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.mix_sample   <= (item_r.kind == mvsm_pkg::KIND_TICK) ? sat : 8'sd0;
      out_data_r.sample_valid <= item_r.kind == mvsm_pkg::KIND_TICK;
      out_data_r.status       <= (item_r.kind == mvsm_pkg::KIND_START) ?
                                 status_cur : mvsm_pkg::ST_OK;
      out_data_r.active_mask  <= act_pad[mvsm_pkg::MASK_W-1:0];
    end
  end

  assign out_data = out_data_r;

  // a playing voice is always short of its end
  for (genvar v = 0; v < mvsm_pkg::NUM_VOICES; v++) begin : g_chk
    a_pos_below_len: assert property (@(posedge clk) disable iff (!rst_n)
      active_r[v] |-> (pos_r[v] < mvsm_pkg::POS_W'({cnt_r[v], 8'h00})))
      else $error("active voice at or past its end");
  end

  // a mixed sample never carries a start status
  a_tick_status: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (!out_data_r.sample_valid || out_data_r.status == mvsm_pkg::ST_OK))
    else $error("tick result with nonzero status");

  // mix pass starts from a clean accumulator at voice zero
  a_mix_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mix_clear |=> (acc_r == '0 && vidx_r == '0))
    else $error("mix pass not cleared");

endmodule

>>> hdl/mvsm_ctrl.sv
// ----------------------------------------------------------------------------
// mvsm_ctrl
// Sequencer for load, start and tick items and the result handshake.
// ----------------------------------------------------------------------------
module mvsm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  mvsm_pkg::sts_t sts,
  output mvsm_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_RD,
    S_ACC,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = state_r == S_IDLE;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          mvsm_pkg::KIND_LOAD: begin
            cmd.store_write = 1'b1;
            state_nxt       = S_DONE;
          end
          mvsm_pkg::KIND_START: begin
            if (sts.start_bad) begin
              state_nxt = S_DONE;
            end else begin
              cmd.step_load = 1'b1;
              state_nxt     = S_WRITE;
            end
          end
          mvsm_pkg::KIND_TICK: begin
            cmd.mix_clear = 1'b1;
            state_nxt     = S_RD;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_WRITE: begin
        cmd.voice_write = 1'b1;
        state_nxt       = S_DONE;
      end
      // store read issued here, data lands for the accumulate cycle
      S_RD: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.mix_accum = 1'b1;
        state_nxt     = sts.last_voice ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // an accepted beat is decoded in the next cycle
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted beat not decoded");

  // finishing an item always presents a result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished item without result");

  // the registered step hands over to the voice write
  a_step_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_load |=> (state_r == S_WRITE))
    else $error("step load not followed by voice write");

endmodule

>>> hdl/multi_voice_sample_mixer.sv
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Byte sample store with playback voices mixed to one signed 8-bit stream.
// ----------------------------------------------------------------------------
// One item is handled at a time; a result beat waits in an output register
// while the next item is taken. From the accept, a load, a rejected start
// and an unused kind go from decode straight to the result load; a tick
// makes one registered store read and one accumulate per voice on the single
// read port; an accepted start first registers the step rate*256/OUT_RATE
// from a reciprocal multiply and then writes the voice. The result load
// waits while the output register holds a beat not yet taken, and the
// sequencer then goes back to idle before the next item is accepted. The
// sample store needs no clearing after reset: reading a byte that was never
// loaded gives an arbitrary value.
module multi_voice_sample_mixer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mvsm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mvsm_pkg::out_t out_data
);

  mvsm_pkg::cmd_t cmd;
  mvsm_pkg::sts_t sts;

  // sequencer
  mvsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, voices and mix
  mvsm_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

>>> test/tb_multi_voice_sample_mixer.sv
// ----------------------------------------------------------------------------
// tb_multi_voice_sample_mixer
// Self-checking bench for the multi-voice sample mixer. A short table of
// directed beats covers the error codes, store wrap, zero count, zero step,
// restart and both saturation limits. Random beats follow: sample loads,
// voice starts and ticks, with gaps on the input and stalls on the output.
// Each result is checked against a fixed row value or an in-bench voice model.
// ----------------------------------------------------------------------------
module tb_multi_voice_sample_mixer;

  localparam int CLK_HALF    = 6;
  localparam int TOTAL_BEATS = 1850;
  localparam int CALM_BEATS  = TOTAL_BEATS * 85 / 100;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 20;
  localparam int REPORT_MAX  = 10;

  localparam logic [1:0]     KIND_UNUSED = 2'd3;
  localparam mvsm_pkg::out_t PREDICTED   = '0;

  typedef struct packed {
    mvsm_pkg::in_t  item;
    logic           fixed;
    mvsm_pkg::out_t want;
  } dir_row_t;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  mvsm_pkg::in_t  in_data   = '0;
  logic           out_ready = 1'b0;
  logic           in_ready;
  logic           out_valid;
  mvsm_pkg::out_t out_data;

  // mirror of the block state
  logic [7:0]                  sample_mem    [mvsm_pkg::STORE_DEPTH];
  bit                          sample_loaded [mvsm_pkg::STORE_DEPTH];
  bit                          voice_on      [mvsm_pkg::NUM_VOICES];
  logic [15:0]                 voice_base    [mvsm_pkg::NUM_VOICES];
  logic [mvsm_pkg::STEP_W-1:0] voice_step    [mvsm_pkg::NUM_VOICES];
  logic [mvsm_pkg::POS_W-1:0]  voice_pos     [mvsm_pkg::NUM_VOICES];
  logic [23:0]                 voice_len     [mvsm_pkg::NUM_VOICES];

  mvsm_pkg::out_t mix_expected [$];
  dir_row_t       dir_rows     [$];
  mvsm_pkg::out_t head_result;
  int             mismatches = 0;
  int             beats_sent = 0;
  int             stall_left = 0;
  int             cycles     = 0;
  bit             idle_on    = 1'b0;

  multi_voice_sample_mixer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, mix_expected.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic mvsm_pkg::in_t make_beat(logic [1:0] kind, logic [15:0] addr,
                                              logic [7:0] data, logic [2:0] voice,
                                              logic [15:0] fmt, logic [15:0] rate,
                                              logic [15:0] count);
    return {kind, addr, data, voice, fmt, rate, count};
  endfunction

  function automatic mvsm_pkg::out_t make_result(logic [7:0] mix, logic valid,
                                                 logic [1:0] st, logic [3:0] mask);
    return {mix, valid, st, mask};
  endfunction

  // all fields random, the kind given
  function automatic mvsm_pkg::in_t rand_beat(logic [1:0] kind);
    return make_beat(kind, 16'($urandom), 8'($urandom), 3'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
  endfunction

  // applies one beat to the mirror and returns the result it causes
  function automatic mvsm_pkg::out_t mixer_predict(mvsm_pkg::in_t it);
    mvsm_pkg::out_t res;
    int             sum;
    logic [15:0]    rd_addr;
    logic [23:0]    scaled;
    res = '0;
    case (it.kind)
      mvsm_pkg::KIND_LOAD: begin
        sample_mem[it.address]    = it.data_byte;
        sample_loaded[it.address] = 1'b1;
      end
      mvsm_pkg::KIND_START: begin
        if (it.voice >= mvsm_pkg::NUM_VOICES) begin
          res.status = mvsm_pkg::ST_BAD_VOICE;
        end else if (it.format_code != mvsm_pkg::FORMAT_OK) begin
          res.status = mvsm_pkg::ST_BAD_FORMAT;
        end else begin
          scaled               = {it.sample_rate, 8'h00};
          voice_base[it.voice] = it.address;
          voice_step[it.voice] = mvsm_pkg::STEP_W'(scaled / mvsm_pkg::OUT_RATE);
          voice_len[it.voice]  = {it.sample_count, 8'h00};
          voice_pos[it.voice]  = '0;
          voice_on[it.voice]   = (it.sample_count != 16'd0);
        end
      end
      mvsm_pkg::KIND_TICK: begin
        sum = 0;
        for (int v = 0; v < mvsm_pkg::NUM_VOICES; v++) begin
          if (voice_on[v]) begin
            rd_addr = voice_base[v] + voice_pos[v][23:8];
            sum += int'(sample_mem[rd_addr]) - 128;
            voice_pos[v] += mvsm_pkg::POS_W'(voice_step[v]);
            if (voice_pos[v] >= mvsm_pkg::POS_W'(voice_len[v])) voice_on[v] = 1'b0;
          end
        end
        if (sum > mvsm_pkg::MIX_MAX) sum = mvsm_pkg::MIX_MAX;
        if (sum < mvsm_pkg::MIX_MIN) sum = mvsm_pkg::MIX_MIN;
        res.mix_sample   = sum[7:0];
        res.sample_valid = 1'b1;
      end
      default: ;
    endcase
    for (int v = 0; v < mvsm_pkg::NUM_VOICES && v < mvsm_pkg::MASK_W; v++)
      res.active_mask[v] = voice_on[v];
    return res;
  endfunction

  // drive one input beat, then record what it should produce
  task automatic send_beat(input mvsm_pkg::in_t it, input logic fixed,
                           input mvsm_pkg::out_t want);
    mvsm_pkg::out_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predicted = mixer_predict(it);
    mix_expected.push_back(fixed ? want : predicted);
    if (it.kind != KIND_UNUSED) beats_sent++;
  endtask

  // hold off input until every pending result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (mix_expected.size() != 0);
  endtask

  // ticks, each preceded by loads of any byte an active voice is about to read
  task automatic tick_beats(input int n);
    mvsm_pkg::in_t it;
    logic [15:0]   rd_addr;
    for (int k = 0; k < n; k++) begin
      for (int v = 0; v < mvsm_pkg::NUM_VOICES; v++) begin
        rd_addr = voice_base[v] + voice_pos[v][23:8];
        if (voice_on[v] && !sample_loaded[rd_addr]) begin
          it         = rand_beat(mvsm_pkg::KIND_LOAD);
          it.address = rd_addr;
          send_beat(it, 1'b0, PREDICTED);
        end
      end
      send_beat(rand_beat(mvsm_pkg::KIND_TICK), 1'b0, PREDICTED);
    end
  endtask

  // result side: check each beat, stall in random bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (mix_expected.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected result beat: mix %0d valid %0b status %0d mask %h",
                   out_data.mix_sample, out_data.sample_valid, out_data.status,
                   out_data.active_mask);
        mismatches++;
      end else begin
        head_result = mix_expected.pop_front();
        if (out_data.mix_sample !== head_result.mix_sample ||
            out_data.sample_valid !== head_result.sample_valid ||
            out_data.status !== head_result.status ||
            out_data.active_mask !== head_result.active_mask) begin
          if (mismatches < REPORT_MAX)
            $display("mismatch at cycle %0d: mix %0d/%0d valid %0b/%0b status %0d/%0d mask %h/%h",
                     cycles, head_result.mix_sample, out_data.mix_sample,
                     head_result.sample_valid, out_data.sample_valid,
                     head_result.status, out_data.status,
                     head_result.active_mask, out_data.active_mask);
          mismatches++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    mvsm_pkg::in_t it;
    int            len;
    int            pick;
    logic [15:0]   base;
    bit            mid_drained;
    mid_drained = 1'b0;
    for (int v = 0; v < mvsm_pkg::NUM_VOICES; v++) begin
      voice_on[v]   = 1'b0;
      voice_base[v] = '0;
      voice_step[v] = '0;
      voice_pos[v]  = '0;
      voice_len[v]  = '0;
    end

    // directed rows: tick after reset, unused kind, error codes, zero count
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_TICK, 16'h0000, 8'h00, 3'd0, 16'h0000,
                                  16'h0000, 16'h0000), 1'b1,
                        make_result(8'h00, 1'b1, mvsm_pkg::ST_OK, 4'h0)});
    dir_rows.push_back({make_beat(KIND_UNUSED, 16'hFFFF, 8'hFF, 3'd7, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF), 1'b1,
                        make_result(8'h00, 1'b0, mvsm_pkg::ST_OK, 4'h0)});
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_START, 16'hFFFF, 8'h00, 3'd7,
                                  mvsm_pkg::FORMAT_OK, 16'hFFFF, 16'hFFFF), 1'b1,
                        make_result(8'h00, 1'b0, mvsm_pkg::ST_BAD_VOICE, 4'h0)});
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_START, 16'h0000, 8'h00, 3'd0, 16'h0000,
                                  16'd11025, 16'h0001), 1'b1,
                        make_result(8'h00, 1'b0, mvsm_pkg::ST_BAD_FORMAT, 4'h0)});
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_START, 16'h0000, 8'h00, 3'd4, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF), 1'b1,
                        make_result(8'h00, 1'b0, mvsm_pkg::ST_BAD_VOICE, 4'h0)});
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_START, 16'h0000, 8'h00, 3'd1,
                                  mvsm_pkg::FORMAT_OK, 16'd11025, 16'h0000), 1'b1,
                        make_result(8'h00, 1'b0, mvsm_pkg::ST_OK, 4'h0)});
    // three bytes across the top of the store, played at step 1.0
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_LOAD, 16'hFFFF, 8'hFF, 3'd0, 16'h0000,
                                  16'h0000, 16'h0000), 1'b1,
                        make_result(8'h00, 1'b0, mvsm_pkg::ST_OK, 4'h0)});
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_LOAD, 16'h0000, 8'h00, 3'd0, 16'h0000,
                                  16'h0000, 16'h0000), 1'b1,
                        make_result(8'h00, 1'b0, mvsm_pkg::ST_OK, 4'h0)});
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_LOAD, 16'h0001, 8'h80, 3'd0, 16'h0000,
                                  16'h0000, 16'h0000), 1'b1,
                        make_result(8'h00, 1'b0, mvsm_pkg::ST_OK, 4'h0)});
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_START, 16'hFFFF, 8'h00, 3'd0,
                                  mvsm_pkg::FORMAT_OK, 16'd11025, 16'h0003), 1'b1,
                        make_result(8'h00, 1'b0, mvsm_pkg::ST_OK, 4'h1)});
    for (int k = 0; k < 3; k++)
      dir_rows.push_back({make_beat(mvsm_pkg::KIND_TICK, 16'h0000, 8'h00, 3'd0, 16'h0000,
                                    16'h0000, 16'h0000), 1'b0, PREDICTED});
    // rate too low for a nonzero step: voice holds its first byte
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_LOAD, 16'h1234, 8'h90, 3'd0, 16'h0000,
                                  16'h0000, 16'h0000), 1'b0, PREDICTED});
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_START, 16'h1234, 8'h00, 3'd2,
                                  mvsm_pkg::FORMAT_OK, 16'd43, 16'hFFFF), 1'b0, PREDICTED});
    for (int k = 0; k < 2; k++)
      dir_rows.push_back({make_beat(mvsm_pkg::KIND_TICK, 16'h0000, 8'h00, 3'd0, 16'h0000,
                                    16'h0000, 16'h0000), 1'b0, PREDICTED});
    // three voices on 0xff saturate high, voice 2 restarted while playing
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_LOAD, 16'h2000, 8'hFF, 3'd0, 16'h0000,
                                  16'h0000, 16'h0000), 1'b0, PREDICTED});
    for (int v = 0; v < 3; v++)
      dir_rows.push_back({make_beat(mvsm_pkg::KIND_START, 16'h2000, 8'h00, 3'(v),
                                    mvsm_pkg::FORMAT_OK, 16'd11025, 16'h0001),
                          1'b0, PREDICTED});
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_TICK, 16'h0000, 8'h00, 3'd0, 16'h0000,
                                  16'h0000, 16'h0000), 1'b1,
                        make_result(8'h7F, 1'b1, mvsm_pkg::ST_OK, 4'h0)});
    // three voices on 0x00 saturate low
    for (int v = 0; v < 4; v++)
      if (v != 2)
        dir_rows.push_back({make_beat(mvsm_pkg::KIND_START, 16'h0000, 8'h00, 3'(v),
                                      mvsm_pkg::FORMAT_OK, 16'd11025, 16'h0001),
                            1'b0, PREDICTED});
    dir_rows.push_back({make_beat(mvsm_pkg::KIND_TICK, 16'h0000, 8'h00, 3'd0, 16'h0000,
                                  16'h0000, 16'h0000), 1'b1,
                        make_result(8'h80, 1'b1, mvsm_pkg::ST_OK, 4'h0)});

    // reset
    repeat (5) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on  = 1'b1;
    @(posedge clk);

    // directed part
    foreach (dir_rows[i]) send_beat(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
    drain_results();

    // random part
    while (beats_sent < TOTAL_BEATS) begin
      idle_on = ((beats_sent / 120) % 3 != 2) && (beats_sent < CALM_BEATS);
      if (!mid_drained && beats_sent >= TOTAL_BEATS / 2) begin
        drain_results();
        mid_drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // short sound: load it, start a voice on it, play a few ticks
        len  = $urandom_range(1, 12);
        base = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 6))
                                            : 16'($urandom);
        for (int i = 0; i < len; i++) begin
          it         = rand_beat(mvsm_pkg::KIND_LOAD);
          it.address = base + 16'(i);
          send_beat(it, 1'b0, PREDICTED);
        end
        it              = rand_beat(mvsm_pkg::KIND_START);
        it.address      = base;
        it.voice        = 3'($urandom_range(0, mvsm_pkg::NUM_VOICES - 1));
        it.format_code  = mvsm_pkg::FORMAT_OK;
        it.sample_count = 16'($urandom_range(1, len));
        case ($urandom_range(0, 3))
          0:       it.sample_rate = 16'($urandom_range(0, 43));
          1:       it.sample_rate = 16'(mvsm_pkg::OUT_RATE);
          2:       it.sample_rate = 16'($urandom_range(0, 22050));
          default: it.sample_rate = 16'($urandom);
        endcase
        send_beat(it, 1'b0, PREDICTED);
        tick_beats($urandom_range(0, 6));
      end else if (pick < 70) begin
        tick_beats($urandom_range(1, 8));
      end else if (pick < 85) begin
        // any start, mostly with a valid format
        it = rand_beat(mvsm_pkg::KIND_START);
        if ($urandom_range(0, 3) != 0) it.format_code = mvsm_pkg::FORMAT_OK;
        send_beat(it, 1'b0, PREDICTED);
      end else if (pick < 95) begin
        send_beat(rand_beat(mvsm_pkg::KIND_LOAD), 1'b0, PREDICTED);
      end else begin
        send_beat(rand_beat(KIND_UNUSED), 1'b0, PREDICTED);
      end
    end

    // wind down
    idle_on = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/mvsm_pkg.sv
hdl/mvsm_ram.sv
hdl/mvsm_datapath.sv
hdl/mvsm_ctrl.sv
hdl/multi_voice_sample_mixer.sv
test/tb_multi_voice_sample_mixer.sv
